// ===== src/mpce_pkg.sv =====
`timescale 1ns / 1ps
// mpce_pkg: codes, control word format and microprogram of the patch code engine
package mpce_pkg;

  // beat layout
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 3;

  localparam logic [1:0] MODE_CODE = 2'd0;
  localparam logic [1:0] MODE_HWR  = 2'd1;
  localparam logic [1:0] MODE_HRD  = 2'd2;

  localparam logic [7:0] KIND_CONST8  = 8'h30;
  localparam logic [7:0] KIND_CONST16 = 8'h80;
  localparam logic [7:0] KIND_INC16   = 8'h10;
  localparam logic [7:0] KIND_DEC16   = 8'h11;
  localparam logic [7:0] KIND_INC8    = 8'h20;
  localparam logic [7:0] KIND_DEC8    = 8'h21;
  localparam logic [7:0] KIND_SLIDE   = 8'h50;
  localparam logic [7:0] KIND_COPY    = 8'hC2;
  localparam logic [7:0] KIND_EQ8     = 8'hE0;
  localparam logic [7:0] KIND_NE8     = 8'hE1;
  localparam logic [7:0] KIND_LT8     = 8'hE2;
  localparam logic [7:0] KIND_GT8     = 8'hE3;
  localparam logic [7:0] KIND_EQ16    = 8'hD0;
  localparam logic [7:0] KIND_NE16    = 8'hD1;
  localparam logic [7:0] KIND_LT16    = 8'hD2;
  localparam logic [7:0] KIND_GT16    = 8'hD3;

  localparam logic [1:0] TEST_EQ = 2'd0;
  localparam logic [1:0] TEST_NE = 2'd1;
  localparam logic [1:0] TEST_LT = 2'd2;
  localparam logic [1:0] TEST_GT = 2'd3;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_SKIP  = 2'd1;
  localparam logic [1:0] PEND_SLIDE = 2'd2;
  localparam logic [1:0] PEND_COPY  = 2'd3;

  typedef enum logic [2:0] {
    OC_WROTE   = 3'd0,
    OC_TRUE    = 3'd1,
    OC_FALSE   = 3'd2,
    OC_SKIPPED = 3'd3,
    OC_HEADER  = 3'd4,
    OC_IGNORED = 3'd5,
    OC_HOST    = 3'd6
  } outcome_e;

  typedef logic [4:0] pc_t;

  typedef enum logic [1:0] {RD_NONE, RD_A, RD_A1, RD_B} rd_e;
  typedef enum logic [2:0] {WR_NONE, WR_A_LO, WR_A1_HI, WR_A_SUM, WR_A_RD} wr_e;
  typedef enum logic [1:0] {NX_NEXT, NX_GOTO, NX_LOOP} nx_e;

  typedef struct packed {
    rd_e  rd;
    wr_e  wr;
    logic ld_lo;
    logic ld_val;
    logic ld_rb;
    logic byte_mode;
    logic test;
    logic slide_step;
    logic copy_step;
    logic fin;
    nx_e  nxt;
    pc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    pc_t  entry;
    logic cnt_last;
    logic out_free;
  } seq_in_t;

  // microprogram entry points and steps
  localparam pc_t UA_FIN       = 5'd0;
  localparam pc_t UA_HRD       = 5'd2;
  localparam pc_t UA_HRD_1     = 5'd3;
  localparam pc_t UA_CONST8    = 5'd4;
  localparam pc_t UA_CONST16   = 5'd5;
  localparam pc_t UA_CONST16_1 = 5'd6;
  localparam pc_t UA_RMW8      = 5'd7;
  localparam pc_t UA_RMW8_1    = 5'd8;
  localparam pc_t UA_RMW16     = 5'd9;
  localparam pc_t UA_RMW16_1   = 5'd10;
  localparam pc_t UA_RMW16_2   = 5'd11;
  localparam pc_t UA_RMW16_3   = 5'd12;
  localparam pc_t UA_TEST8     = 5'd13;
  localparam pc_t UA_TEST8_1   = 5'd14;
  localparam pc_t UA_TEST16    = 5'd15;
  localparam pc_t UA_TEST16_1  = 5'd16;
  localparam pc_t UA_TEST16_2  = 5'd17;
  localparam pc_t UA_SLIDE8    = 5'd18;
  localparam pc_t UA_SLIDE16   = 5'd19;
  localparam pc_t UA_SLIDE16_1 = 5'd20;
  localparam pc_t UA_COPY      = 5'd21;
  localparam pc_t UA_COPY_1    = 5'd22;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '0;
    w.nxt = NX_GOTO;
    w.target = UA_FIN;
    unique case (pc)
      UA_FIN:       w.fin = 1'b1;
      UA_HRD:       begin w.rd = RD_A; w.nxt = NX_NEXT; end
      UA_HRD_1:     w.ld_rb = 1'b1;
      UA_CONST8:    w.wr = WR_A_LO;
      UA_CONST16:   begin w.wr = WR_A_LO; w.nxt = NX_NEXT; end
      UA_CONST16_1: w.wr = WR_A1_HI;
      UA_RMW8:      begin w.rd = RD_A; w.nxt = NX_NEXT; end
      UA_RMW8_1:    begin w.wr = WR_A_SUM; w.byte_mode = 1'b1; end
      UA_RMW16:     begin w.rd = RD_A; w.nxt = NX_NEXT; end
      UA_RMW16_1:   begin w.rd = RD_A1; w.ld_lo = 1'b1; w.nxt = NX_NEXT; end
      UA_RMW16_2:   begin w.wr = WR_A_SUM; w.ld_val = 1'b1; w.nxt = NX_NEXT; end
      UA_RMW16_3:   w.wr = WR_A1_HI;
      UA_TEST8:     begin w.rd = RD_A; w.nxt = NX_NEXT; end
      UA_TEST8_1:   begin w.test = 1'b1; w.byte_mode = 1'b1; end
      UA_TEST16:    begin w.rd = RD_A; w.nxt = NX_NEXT; end
      UA_TEST16_1:  begin w.rd = RD_A1; w.ld_lo = 1'b1; w.nxt = NX_NEXT; end
      UA_TEST16_2:  w.test = 1'b1;
      UA_SLIDE8: begin
        w.wr = WR_A_LO;
        w.slide_step = 1'b1;
        w.nxt = NX_LOOP;
        w.target = UA_SLIDE8;
      end
      UA_SLIDE16:   begin w.wr = WR_A_LO; w.nxt = NX_NEXT; end
      UA_SLIDE16_1: begin
        w.wr = WR_A1_HI;
        w.slide_step = 1'b1;
        w.nxt = NX_LOOP;
        w.target = UA_SLIDE16;
      end
      UA_COPY:      begin w.rd = RD_B; w.nxt = NX_NEXT; end
      UA_COPY_1: begin
        w.wr = WR_A_RD;
        w.copy_step = 1'b1;
        w.nxt = NX_LOOP;
        w.target = UA_COPY;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ===== src/mpce_seq.sv =====
`timescale 1ns / 1ps
// mpce_seq: step counter and control store of the patch code engine
module mpce_seq
  import mpce_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  seq_in_t sin_i,
  output ctrl_t   ctrl_o,
  output logic    idle_o
);

  logic  busy_q, busy_d;
  pc_t   pc_q, pc_d;
  ctrl_t word;

  assign word   = ucode(pc_q);
  assign idle_o = !busy_q;
  assign ctrl_o = busy_q ? word : '0;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (sin_i.start) begin
        busy_d = 1'b1;
        pc_d   = sin_i.entry;
      end
    end else if (word.fin) begin
      if (sin_i.out_free) begin
        busy_d = 1'b0;
      end
    end else begin
      unique case (word.nxt)
        NX_NEXT: pc_d = pc_q + pc_t'(1);
        NX_GOTO: pc_d = word.target;
        NX_LOOP: pc_d = sin_i.cnt_last ? UA_FIN : word.target;
        default: pc_d = UA_FIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= UA_FIN;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

// ===== src/memory_patch_code_engine.sv =====
`timescale 1ns / 1ps
// memory_patch_code_engine: patch code interpreter over an internal byte memory
//
//   channel  dir  handshake                   payload
//   s_axis   in   s_axis_tvalid/tready        tdata: kind, target, operand, host addr, byte
//                                             tuser: mode, tlast: group end
//   m_axis   out  m_axis_tvalid/tready        tdata: read byte, write count
//                                             tuser: outcome
//
// one item at a time; from the accepting edge the item occupies the sequencer through its
// microprogram: const8 and host write store one byte, const16 two, inc/dec and tests read
// first, host read loads the reply byte, slides loop per write and copies read then write per byte
// the single read and single write port of the byte memory set the per-byte cost
// reset clears sequencer, pending header and output register; memory is not cleared
// a held result stalls the sequencer on its final step until the slot frees
module memory_patch_code_engine
  import mpce_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // kind 8, target 21, operand 16, host addr 21, byte 8
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // mode 2
  input  logic                 s_axis_tlast,  // group end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // read byte 8, write count 16
  output logic [M_TUSER_W-1:0] m_axis_tuser   // outcome 3
);

  localparam int unsigned MemDepth = 1 << MEM_ADDR_BITS;

  typedef logic [MEM_ADDR_BITS-1:0] addr_t;

  // input fields
  logic [1:0]  in_mode;
  logic [7:0]  in_kind;
  logic [20:0] in_target;
  logic [15:0] in_operand;
  logic [20:0] in_haddr;
  logic [7:0]  in_hbyte;

  assign in_mode    = s_axis_tuser[1:0];
  assign in_kind    = s_axis_tdata[7:0];
  assign in_target  = s_axis_tdata[28:8];
  assign in_operand = s_axis_tdata[44:29];
  assign in_haddr   = s_axis_tdata[65:45];
  assign in_hbyte   = s_axis_tdata[73:66];

  logic    accept, seq_idle, out_free, fin_go;
  ctrl_t   ctrl;
  seq_in_t sin;

  // control state
  logic [1:0]  pend_q, pend_d;
  logic [20:0] hdr_tgt_q, hdr_tgt_d;
  logic [15:0] hdr_opd_q, hdr_opd_d;
  logic        out_valid_q, out_valid_d;

  // datapath
  addr_t       a_q, a_d, b_q, b_d, a1;
  logic [15:0] val_q, val_d, cnt_q, cnt_d;
  logic [7:0]  lo_q, lo_d, rdata_q;
  logic [1:0]  ksel_q, ksel_d;
  logic        last_q, last_d;
  outcome_e    oc_q, oc_d, m_oc_q, m_oc_d;
  logic [15:0] wc_q, wc_d, m_wc_q, m_wc_d;
  logic [7:0]  rb_q, rb_d, m_rb_q, m_rb_d;

  // dispatch decode
  pc_t         entry;
  outcome_e    disp_oc;
  logic [15:0] disp_wc;
  addr_t       disp_a;
  logic [15:0] disp_val;
  logic [1:0]  pend_n;
  logic        hdr_ld;

  // alu
  logic [15:0] cmp_word, cmp_opnd, sum;
  logic        pass;

  // memory ports
  logic [7:0] mem_q [MemDepth];
  logic       mem_re, mem_we;
  addr_t      mem_raddr, mem_waddr;
  logic [7:0] mem_wdata;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = seq_idle;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fin_go        = ctrl.fin && out_free;
  assign a1            = a_q + addr_t'(1);

  assign sin.start    = accept;
  assign sin.entry    = entry;
  assign sin.cnt_last = (cnt_q == 16'd1);
  assign sin.out_free = out_free;

  mpce_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sin_i  (sin),
    .ctrl_o (ctrl),
    .idle_o (seq_idle)
  );

  always_comb begin
    entry    = UA_FIN;
    disp_oc  = OC_IGNORED;
    disp_wc  = '0;
    disp_a   = addr_t'(in_target);
    disp_val = in_operand;
    pend_n   = pend_q;
    hdr_ld   = 1'b0;
    unique case (in_mode)
      MODE_CODE: begin
        pend_n = PEND_NONE;
        unique case (pend_q)
          PEND_SKIP: disp_oc = OC_SKIPPED;
          PEND_SLIDE: begin
            if (in_kind == KIND_CONST8 || in_kind == KIND_CONST16) begin
              disp_oc = OC_WROTE;
              disp_wc = {8'h00, hdr_tgt_q[15:8]};
              if (hdr_tgt_q[15:8] != 8'h00) begin
                entry = (in_kind == KIND_CONST8) ? UA_SLIDE8 : UA_SLIDE16;
              end
            end
          end
          PEND_COPY: begin
            disp_oc = OC_WROTE;
            disp_wc = hdr_opd_q;
            if (hdr_opd_q != 16'h0000) begin
              entry = UA_COPY;
            end
          end
          default: begin
            case (in_kind) inside
              KIND_CONST8: begin
                entry = UA_CONST8; disp_oc = OC_WROTE; disp_wc = 16'd1;
              end
              KIND_CONST16: begin
                entry = UA_CONST16; disp_oc = OC_WROTE; disp_wc = 16'd1;
              end
              KIND_INC16, KIND_DEC16: begin
                entry = UA_RMW16; disp_oc = OC_WROTE; disp_wc = 16'd1;
              end
              KIND_INC8, KIND_DEC8: begin
                entry = UA_RMW8; disp_oc = OC_WROTE; disp_wc = 16'd1;
              end
              KIND_SLIDE, KIND_COPY: begin
                if (!s_axis_tlast) begin
                  disp_oc = OC_HEADER;
                  hdr_ld  = 1'b1;
                  pend_n  = (in_kind == KIND_SLIDE) ? PEND_SLIDE : PEND_COPY;
                end
              end
              KIND_EQ8, KIND_NE8, KIND_LT8, KIND_GT8: begin
                entry = UA_TEST8; disp_oc = OC_TRUE;
              end
              KIND_EQ16, KIND_NE16, KIND_LT16, KIND_GT16: begin
                entry = UA_TEST16; disp_oc = OC_TRUE;
              end
              default: ;
            endcase
          end
        endcase
      end
      MODE_HWR: begin
        entry    = UA_CONST8;
        disp_oc  = OC_HOST;
        disp_a   = addr_t'(in_haddr);
        disp_val = {8'h00, in_hbyte};
      end
      MODE_HRD: begin
        entry   = UA_HRD;
        disp_oc = OC_HOST;
        disp_a  = addr_t'(in_haddr);
      end
      default: ;
    endcase
  end

  // shared add and compare; byte mode looks at the low byte only
  always_comb begin
    cmp_word = ctrl.byte_mode ? {8'h00, rdata_q} : {rdata_q, lo_q};
    cmp_opnd = ctrl.byte_mode ? {8'h00, val_q[7:0]} : val_q;
    sum      = ksel_q[0] ? (cmp_word - cmp_opnd) : (cmp_word + cmp_opnd);
    case (ksel_q)
      TEST_EQ: pass = (cmp_word == cmp_opnd);
      TEST_NE: pass = (cmp_word != cmp_opnd);
      TEST_LT: pass = (cmp_word < cmp_opnd);
      default: pass = (cmp_word > cmp_opnd);
    endcase
  end

  always_comb begin
    mem_re    = 1'b1;
    mem_raddr = a_q;
    unique case (ctrl.rd)
      RD_A:    mem_raddr = a_q;
      RD_A1:   mem_raddr = a1;
      RD_B:    mem_raddr = b_q;
      default: mem_re = 1'b0;
    endcase
    mem_we    = 1'b1;
    mem_waddr = a_q;
    mem_wdata = val_q[7:0];
    unique case (ctrl.wr)
      WR_A_LO: mem_wdata = val_q[7:0];
      WR_A1_HI: begin
        mem_waddr = a1;
        mem_wdata = val_q[15:8];
      end
      WR_A_SUM: mem_wdata = sum[7:0];
      WR_A_RD:  mem_wdata = rdata_q;
      default:  mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    pend_d    = pend_q;
    hdr_tgt_d = hdr_tgt_q;
    hdr_opd_d = hdr_opd_q;
    if (accept) begin
      pend_d = pend_n;
      if (hdr_ld) begin
        hdr_tgt_d = in_target;
        hdr_opd_d = in_operand;
      end
    end else if (ctrl.test && !pass && !last_q) begin
      pend_d = PEND_SKIP;
    end
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    lo_d   = lo_q;
    ksel_d = ksel_q;
    last_d = last_q;
    oc_d   = oc_q;
    wc_d   = wc_q;
    rb_d   = rb_q;
    if (accept) begin
      a_d    = disp_a;
      b_d    = addr_t'(hdr_tgt_q);
      val_d  = disp_val;
      cnt_d  = disp_wc;
      ksel_d = in_kind[1:0];
      last_d = s_axis_tlast;
      oc_d   = disp_oc;
      wc_d   = disp_wc;
      rb_d   = '0;
    end else begin
      if (ctrl.ld_lo) begin
        lo_d = rdata_q;
      end
      if (ctrl.ld_val) begin
        val_d = sum;
      end
      if (ctrl.ld_rb) begin
        rb_d = rdata_q;
      end
      if (ctrl.test) begin
        oc_d = pass ? OC_TRUE : OC_FALSE;
      end
      if (ctrl.slide_step) begin
        a_d   = a_q + {{(MEM_ADDR_BITS-8){hdr_tgt_q[7]}}, hdr_tgt_q[7:0]};
        val_d = val_q + {{8{hdr_opd_q[7]}}, hdr_opd_q[7:0]};
        cnt_d = cnt_q - 16'd1;
      end
      if (ctrl.copy_step) begin
        a_d   = a1;
        b_d   = b_q + addr_t'(1);
        cnt_d = cnt_q - 16'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    m_oc_d      = m_oc_q;
    m_wc_d      = m_wc_q;
    m_rb_d      = m_rb_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
      m_oc_d      = oc_q;
      m_wc_d      = wc_q;
      m_rb_d      = rb_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= PEND_NONE;
      hdr_tgt_q   <= '0;
      hdr_opd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      hdr_tgt_q   <= hdr_tgt_d;
      hdr_opd_q   <= hdr_opd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    lo_q   <= lo_d;
    ksel_q <= ksel_d;
    last_q <= last_d;
    oc_q   <= oc_d;
    wc_q   <= wc_d;
    rb_q   <= rb_d;
    m_oc_q <= m_oc_d;
    m_wc_q <= m_wc_d;
    m_rb_q <= m_rb_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {m_wc_q, m_rb_q};
  assign m_axis_tuser  = m_oc_q;

endmodule

// ===== src/mpce_checker.sv =====
`timescale 1ns / 1ps
// mpce_checker: port level checks of the patch code engine and its binding
module mpce_checker
  import mpce_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // a held result beat keeps its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a new result follows a busy sequencer
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item");

  // only writing codes report writes, only host beats return a byte
  a_count_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != OC_WROTE) |-> (m_axis_tdata[23:8] == 16'h0000))
    else $error("write count on a non-writing code");

  a_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != OC_HOST) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("read byte on a non-host beat");

endmodule

bind memory_patch_code_engine mpce_checker u_mpce_checker (.*);

// ===== tb/sv/memory_patch_code_engine_tb.sv =====
`timescale 1ns / 1ps
// memory_patch_code_engine_tb: stream testbench checking every reply beat against a patch code predictor
module memory_patch_code_engine_tb;
  import mpce_pkg::*;

  localparam logic [1:0]  MODE_BAD = 2'd3;
  localparam int unsigned WIN_SIZE = 64;
  localparam logic [20:0] WIN_BASE = 21'h1FFFE0;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  kind;
    logic [20:0] target;
    logic [15:0] operand;
    logic        grp_end;
    logic [20:0] haddr;
    logic [7:0]  hbyte;
    bit          drain;
  } code_beat_t;

  typedef struct {
    logic [7:0]  rd_byte;
    outcome_e    outcome;
    logic [15:0] writes;
  } reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // kind 8, target 21, operand 16, host addr 21, byte 8
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // mode 2
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // read byte 8, write count 16
  logic [M_TUSER_W-1:0] m_axis_tuser;       // outcome 3

  // predictor state
  logic [7:0]  mem_img [int unsigned];
  logic [1:0]  pend_kind = PEND_NONE;
  logic [20:0] hdr_target = '0;
  logic [15:0] hdr_operand = '0;

  code_beat_t  beat_q[$];
  reply_t      reply_q[$];
  logic [20:0] host_wr_q[$];
  code_beat_t  cur_beat;
  int unsigned n_queued = 0;
  int unsigned next_drain = 150;
  int unsigned sent_cnt = 0;
  int unsigned reply_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  memory_patch_code_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic [7:0] mem_rd8(logic [20:0] a);
    return mem_img.exists(a) ? mem_img[a] : 8'h00;
  endfunction

  function automatic void mem_wr8(logic [20:0] a, logic [7:0] v);
    mem_img[a] = v;
  endfunction

  function automatic logic [15:0] mem_rd16(logic [20:0] a);
    return {mem_rd8(a + 21'd1), mem_rd8(a)};
  endfunction

  function automatic void mem_wr16(logic [20:0] a, logic [15:0] v);
    mem_wr8(a, v[7:0]);
    mem_wr8(a + 21'd1, v[15:8]);
  endfunction

  function automatic bit cmp_true(logic [1:0] sel, logic [15:0] m, logic [15:0] v);
    case (sel)
      TEST_EQ: return m == v;
      TEST_NE: return m != v;
      TEST_LT: return m < v;
      default: return m > v;
    endcase
  endfunction

  // executes one beat on the predictor state and returns the reply it causes
  function automatic reply_t run_beat(code_beat_t b);
    reply_t      r;
    logic [1:0]  pk;
    logic [20:0] ta;
    logic [15:0] v;
    int unsigned n;
    r.rd_byte = '0;
    r.outcome = OC_IGNORED;
    r.writes = '0;
    case (b.mode)
      MODE_HWR: begin
        mem_wr8(b.haddr, b.hbyte);
        r.outcome = OC_HOST;
      end
      MODE_HRD: begin
        r.rd_byte = mem_rd8(b.haddr);
        r.outcome = OC_HOST;
      end
      MODE_CODE: begin
        pk = pend_kind;
        pend_kind = PEND_NONE;
        if (pk == PEND_SKIP) begin
          r.outcome = OC_SKIPPED;
        end else if (pk == PEND_SLIDE) begin
          if (b.kind == KIND_CONST8 || b.kind == KIND_CONST16) begin
            n = hdr_target[15:8];
            ta = b.target;
            v = b.operand;
            for (int k = 0; k < n; k++) begin
              if (b.kind == KIND_CONST8) mem_wr8(ta, v[7:0]);
              else mem_wr16(ta, v);
              ta = ta + {{13{hdr_target[7]}}, hdr_target[7:0]};
              v = v + {{8{hdr_operand[7]}}, hdr_operand[7:0]};
            end
            r.outcome = OC_WROTE;
            r.writes = 16'(n);
          end
        end else if (pk == PEND_COPY) begin
          for (int k = 0; k < hdr_operand; k++)
            mem_wr8(b.target + 21'(k), mem_rd8(hdr_target + 21'(k)));
          r.outcome = OC_WROTE;
          r.writes = hdr_operand;
        end else begin
          case (b.kind)
            KIND_CONST8, KIND_CONST16, KIND_INC16, KIND_DEC16, KIND_INC8, KIND_DEC8: begin
              r.outcome = OC_WROTE;
              r.writes = 16'd1;
              case (b.kind)
                KIND_CONST8:  mem_wr8(b.target, b.operand[7:0]);
                KIND_CONST16: mem_wr16(b.target, b.operand);
                KIND_INC16:   mem_wr16(b.target, mem_rd16(b.target) + b.operand);
                KIND_DEC16:   mem_wr16(b.target, mem_rd16(b.target) - b.operand);
                KIND_INC8:    mem_wr8(b.target, mem_rd8(b.target) + b.operand[7:0]);
                default:      mem_wr8(b.target, mem_rd8(b.target) - b.operand[7:0]);
              endcase
            end
            KIND_SLIDE, KIND_COPY: begin
              if (!b.grp_end) begin
                pend_kind = (b.kind == KIND_SLIDE) ? PEND_SLIDE : PEND_COPY;
                hdr_target = b.target;
                hdr_operand = b.operand;
                r.outcome = OC_HEADER;
              end
            end
            KIND_EQ8, KIND_NE8, KIND_LT8, KIND_GT8: begin
              if (cmp_true(b.kind[1:0], {8'h00, mem_rd8(b.target)}, {8'h00, b.operand[7:0]})) begin
                r.outcome = OC_TRUE;
              end else begin
                r.outcome = OC_FALSE;
                pend_kind = PEND_SKIP;
              end
            end
            KIND_EQ16, KIND_NE16, KIND_LT16, KIND_GT16: begin
              if (cmp_true(b.kind[1:0], mem_rd16(b.target), b.operand)) begin
                r.outcome = OC_TRUE;
              end else begin
                r.outcome = OC_FALSE;
                pend_kind = PEND_SKIP;
              end
            end
            default: ;
          endcase
        end
        if (b.grp_end) pend_kind = PEND_NONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // stimulus helpers; every read goes to the preloaded window or a host-written byte
  function automatic logic [20:0] win_addr(int unsigned i);
    return WIN_BASE + 21'(i);
  endfunction

  function automatic logic [20:0] read_addr();
    return win_addr($urandom_range(0, WIN_SIZE - 2));
  endfunction

  function automatic logic grp_flag();
    return $urandom_range(0, 3) == 0;
  endfunction

  function automatic bit reads_mem(logic [7:0] kind);
    return kind == KIND_INC16 || kind == KIND_DEC16 || kind == KIND_INC8 || kind == KIND_DEC8
        || kind[7:2] == KIND_EQ8[7:2] || kind[7:2] == KIND_EQ16[7:2];
  endfunction

  function automatic int unsigned idle_len(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cnt % 400 >= 300) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic code_beat_t mk_code(logic [7:0] kind, logic [20:0] target,
                                         logic [15:0] operand, logic grp_end);
    code_beat_t b;
    b.mode = MODE_CODE;
    b.kind = kind;
    b.target = target;
    b.operand = operand;
    b.grp_end = grp_end;
    b.haddr = 21'($urandom);
    b.hbyte = 8'($urandom);
    b.drain = 1'b0;
    return b;
  endfunction

  function automatic code_beat_t mk_host(logic [1:0] mode, logic [20:0] haddr, logic [7:0] hbyte);
    code_beat_t b;
    b = mk_code(8'($urandom), 21'($urandom), 16'($urandom), 1'($urandom));
    b.mode = mode;
    b.haddr = haddr;
    b.hbyte = hbyte;
    return b;
  endfunction

  function automatic code_beat_t any_code(logic [7:0] kind, logic grp_end);
    code_beat_t  b;
    int unsigned i;
    b = mk_code(kind, 21'($urandom), 16'($urandom), grp_end);
    if (kind == KIND_COPY) begin
      i = $urandom_range(0, WIN_SIZE - 1);
      b.target = win_addr(i);
      b.operand = 16'($urandom_range(0, WIN_SIZE - i));
    end else if (reads_mem(kind)) begin
      b.target = read_addr();
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 13))
      0:       return KIND_CONST8;
      1:       return KIND_CONST16;
      2:       return KIND_INC16;
      3:       return KIND_DEC16;
      4:       return KIND_INC8;
      5:       return KIND_DEC8;
      6:       return KIND_SLIDE;
      7:       return KIND_COPY;
      8, 9:    return KIND_EQ8 | 8'($urandom_range(0, 3));
      10, 11:  return KIND_EQ16 | 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic code_beat_t slide_hdr();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = (r < 85) ? $urandom_range(0, 8) : (r < 97) ? $urandom_range(9, 60) : $urandom_range(200, 255);
    return mk_code(KIND_SLIDE, {5'($urandom), 8'(n), 8'($urandom)}, 16'($urandom), 1'b0);
  endfunction

  function automatic code_beat_t host_read();
    logic [20:0] a;
    if (host_wr_q.size() != 0 && $urandom_range(0, 1) == 1)
      a = host_wr_q[$urandom_range(0, host_wr_q.size() - 1)];
    else
      a = win_addr($urandom_range(0, WIN_SIZE - 1));
    return mk_host(MODE_HRD, a, 8'($urandom));
  endfunction

  task automatic push_beat(code_beat_t b);
    if (n_queued >= next_drain) begin
      b.drain = 1'b1;
      next_drain = next_drain + 200 + $urandom_range(0, 200);
    end
    if (b.mode == MODE_HWR) host_wr_q.push_back(b.haddr);
    if (b.mode != MODE_BAD) n_queued++;
    beat_q.push_back(b);
  endtask

  task automatic gen_group();
    int unsigned r;
    logic [20:0] a;
    logic [7:0]  v;
    logic [7:0]  w;
    logic [15:0] op;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      a = (r < 5) ? win_addr($urandom_range(0, WIN_SIZE - 1)) : 21'($urandom);
      push_beat(mk_host(MODE_HWR, a, 8'($urandom)));
    end else if (r < 18) begin
      push_beat(host_read());
    end else if (r < 20) begin
      push_beat(mk_host(MODE_BAD, 21'($urandom), 8'($urandom)));
    end else if (r < 36) begin
      push_beat(any_code(pick_kind(), grp_flag()));
    end else if (r < 54) begin
      // test on bytes of known value, then the code it guards
      a = read_addr();
      v = 8'($urandom);
      w = 8'($urandom);
      push_beat(mk_host(MODE_HWR, a, v));
      push_beat(mk_host(MODE_HWR, a + 21'd1, w));
      op = {w, v} + 16'($urandom_range(0, 2)) - 16'd1;
      if ($urandom_range(0, 4) == 0) op = 16'($urandom);
      push_beat(mk_code(($urandom_range(0, 1) == 1 ? KIND_EQ8 : KIND_EQ16)
                        | 8'($urandom_range(0, 3)), a, op, $urandom_range(0, 7) == 0));
      push_beat(any_code(pick_kind(), grp_flag()));
    end else if (r < 70) begin
      push_beat(slide_hdr());
      if ($urandom_range(0, 4) == 0) push_beat(host_read());
      if ($urandom_range(0, 99) < 85)
        push_beat(mk_code($urandom_range(0, 1) == 1 ? KIND_CONST8 : KIND_CONST16,
                          21'($urandom), 16'($urandom), grp_flag()));
      else
        push_beat(any_code(pick_kind(), grp_flag()));
    end else if (r < 84) begin
      push_beat(any_code(KIND_COPY, 1'b0));
      if ($urandom_range(0, 4) == 0) push_beat(host_read());
      push_beat(any_code(pick_kind(), grp_flag()));
    end else if (r < 88) begin
      push_beat(any_code($urandom_range(0, 1) == 1 ? KIND_SLIDE : KIND_COPY, 1'b1));
      push_beat(any_code(pick_kind(), grp_flag()));
    end else begin
      repeat ($urandom_range(2, 4)) push_beat(any_code(pick_kind(), grp_flag()));
    end
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // sender: holds each beat until taken, then idles for a random gap
  always @(posedge clk_i) begin : driver
    logic busy;
    if (rst_ni) begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(run_beat(cur_beat));
        sent_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (beat_q.size() != 0 && !(beat_q[0].drain && reply_q.size() != 0)) begin
          cur_beat = beat_q.pop_front();
          s_axis_tdata <= S_TDATA_W'({cur_beat.hbyte, cur_beat.haddr, cur_beat.operand,
                                      cur_beat.target, cur_beat.kind});
          s_axis_tuser <= cur_beat.mode;
          s_axis_tlast <= cur_beat.grp_end;
          tx_gap = idle_len(sent_cnt);
          busy = 1'b1;
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  // receiver: checks reply beats and stalls at random, once for a long stretch
  always @(posedge clk_i) begin : monitor
    reply_t want;
    logic   rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          $error("reply beat with no expectation: tdata %0h tuser %0d", m_axis_tdata, m_axis_tuser);
          fail_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata[7:0] !== want.rd_byte) begin
            $error("read_byte expected %0h got %0h", want.rd_byte, m_axis_tdata[7:0]);
            fail_cnt++;
          end
          if (m_axis_tuser !== want.outcome) begin
            $error("outcome expected %0d got %0d", want.outcome, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[23:8] !== want.writes) begin
            $error("write_count expected %0d got %0d", want.writes, m_axis_tdata[23:8]);
            fail_cnt++;
          end
        end
        reply_cnt++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held_once && reply_cnt >= 300) begin
        held_once = 1'b1;
        hold_left = 600;
        rdy = 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rx_gap = ($urandom_range(0, 3) == 0) ? idle_len(reply_cnt) : 0;
        rdy = (rx_gap == 0);
        if (rx_gap != 0) rx_gap--;
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin : stimulus
    int unsigned n_random;
    // preload a window that wraps from the top of memory to the bottom
    for (int i = 0; i < WIN_SIZE; i++) push_beat(mk_host(MODE_HWR, win_addr(i), 8'($urandom)));

    push_beat(mk_host(MODE_HWR, 21'h1FFFFF, 8'hFF));
    push_beat(mk_host(MODE_HRD, 21'h1FFFFF, 8'h00));
    push_beat(mk_code(KIND_EQ8, 21'h1FFFFF, 16'h00FF, 1'b0));
    // false test skips the next code
    push_beat(mk_code(KIND_NE8, 21'h1FFFFF, 16'hFFFF, 1'b0));
    push_beat(mk_code(KIND_CONST8, 21'h000000, 16'h0012, 1'b0));
    // skip dropped at group end
    push_beat(mk_code(KIND_LT16, 21'h1FFFFF, 16'h0000, 1'b1));
    push_beat(mk_code(KIND_CONST16, 21'h1FFFFF, 16'hFFFF, 1'b0));
    // host beats leave a pending skip alone
    push_beat(mk_code(KIND_GT16, 21'h1FFFFF, 16'hFFFF, 1'b0));
    push_beat(mk_host(MODE_HRD, 21'h000000, 8'hFF));
    push_beat(mk_code(KIND_INC16, 21'h1FFFFE, 16'h0001, 1'b0));
    push_beat(mk_code(KIND_INC16, 21'h1FFFFF, 16'hFFFF, 1'b0));
    push_beat(mk_code(KIND_DEC16, 21'h1FFFFE, 16'h0001, 1'b0));
    push_beat(mk_code(KIND_INC8, 21'h000001, 16'h00FF, 1'b0));
    push_beat(mk_code(KIND_DEC8, 21'h000002, 16'hFFFF, 1'b0));
    push_beat(mk_code(KIND_EQ16, 21'h000000, 16'h0000, 1'b0));
    push_beat(mk_code(KIND_LT8, 21'h000003, 16'h00FF, 1'b1));
    push_beat(mk_code(KIND_GT8, 21'h000004, 16'h0000, 1'b1));
    // slide with negative steps, then a slide whose data line is not a constant write
    push_beat(mk_code(KIND_SLIDE, {5'h1F, 8'd4, 8'hFF}, 16'h0080, 1'b0));
    push_beat(mk_code(KIND_CONST16, 21'h000001, 16'hFFFF, 1'b0));
    push_beat(mk_code(KIND_SLIDE, {5'h00, 8'd3, 8'h01}, 16'h0001, 1'b0));
    push_beat(mk_code(KIND_INC8, win_addr(3), 16'h0001, 1'b1));
    // copy out of the window with a host beat in between, then an empty copy
    push_beat(mk_code(KIND_COPY, win_addr(0), 16'd16, 1'b0));
    push_beat(mk_host(MODE_HWR, 21'h100000, 8'h5A));
    push_beat(mk_code(8'hFF, 21'h000100, 16'h0000, 1'b1));
    push_beat(mk_code(KIND_COPY, win_addr(5), 16'd0, 1'b0));
    push_beat(mk_code(KIND_CONST8, 21'h0ABCDE, 16'h0033, 1'b0));
    // header as last code of its group, an unknown kind and the unused mode
    push_beat(mk_code(KIND_SLIDE, 21'h000304, 16'h0001, 1'b1));
    push_beat(mk_code(8'h00, 21'h000000, 16'h0000, 1'b0));
    push_beat(mk_host(MODE_BAD, 21'h1FFFFF, 8'hFF));

    n_random = n_queued + 1200;
    while (n_queued < n_random) gen_group();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (beat_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0);
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
